// ===== rtl/edsu_pkg.sv =====
// Shared types, constants and the decay fraction table of the event decay surface block.
package edsu_pkg;

  localparam int unsigned TIME_BITS  = 40;
  localparam int unsigned RATE_BITS  = 32;
  localparam int unsigned LEVEL_BITS = 16;
  localparam int unsigned FRAC_BITS  = 17;
  localparam int unsigned MUL_A_BITS = 32;
  localparam int unsigned MUL_B_BITS = 20;
  localparam int unsigned MUL_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam logic [63:0] STEP_BASE  = 64'd4283353945;
  localparam logic signed [17:0] ONE_Q88 = 18'sd256;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 32'd1;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [23:0] stamp;
    logic        polarity;
  } event_t;

  typedef struct packed {
    logic [9:0]         out_x;
    logic [8:0]         out_y;
    logic signed [15:0] new_value;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [TIME_BITS-1:0]  stamp_time;
  } pixel_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_AGE,
    ST_MLO,
    ST_MHI,
    ST_EXP,
    ST_TAB,
    ST_MAG,
    ST_RND,
    ST_FIN
  } state_e;

  typedef logic [FRAC_BITS-1:0] frac_tab_t [256];

  // Q1.16 factors 2^-(i/256), built from repeated multiplication by 2^(-1/256)
  function automatic frac_tab_t build_frac_table();
    frac_tab_t   tab;
    logic [63:0] c;
    logic [63:0] p;
    c = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      tab[i] = FRAC_BITS'((c + 64'd32768) >> 16);
      p = c * STEP_BASE;
      c = (p + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TABLE = build_frac_table();

endpackage

// ===== rtl/edsu_stream_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
interface edsu_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/edsu_pixel_mem.sv =====
// Single-port-write, single-port-read pixel store with registered read data.
module edsu_pixel_mem #(
  parameter int unsigned DEPTH = 307200,
  parameter int unsigned WIDTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/event_decay_surface_update_top.sv =====
// Event decay surface top level: running clock, pixel store and decay/update sequencer.
// An event goes through ADDR, READ, AGE, MLO, MHI, EXP, TAB, MAG, RND, FIN in the image,
//   ADDR and FIN outside it; FIN waits while the sink has not taken the previous result. An
//   event is taken only in IDLE, after the last; the 32x20 multiplier is shared by three steps
//   per event and the store does an RMW. Reset: control clears at once, then a clearing pass
//   zeroes all IMAGE_WIDTH*IMAGE_HEIGHT entries before the first event; config always taken.
module event_decay_surface_update_top #(
  parameter int unsigned IMAGE_WIDTH  = 640,
  parameter int unsigned IMAGE_HEIGHT = 480,
  parameter int unsigned STAMP_BITS   = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  edsu_stream_if.sink   evt_i,
  edsu_stream_if.source res_o,
  edsu_stream_if.sink   cfg_i
);

  import edsu_pkg::*;

  localparam int unsigned PIX = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned AW  = $clog2(PIX);
  localparam int unsigned EW  = LEVEL_BITS + TIME_BITS;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [AW-1:0]           clr_q;
  logic [RATE_BITS-1:0]    rate_q;
  logic [TIME_BITS-1:0]    rt_q;
  logic [STAMP_BITS-1:0]   prev_q;
  logic                    out_vld_q;

  // Payload registers
  event_t                  evt_q;
  result_t                 out_q;
  logic                    inr_q;
  logic [AW-1:0]           idx_q;
  logic [TIME_BITS-1:0]    age_q;
  logic                    neg_q;
  logic [LEVEL_BITS-1:0]   mag_q;
  logic [MUL_BITS-1:0]     mul_q;
  logic [MUL_BITS-1:0]     plo_q;
  logic                    zero_q;
  logic [3:0]              n_q;
  logic [7:0]              f_q;
  logic [FRAC_BITS-1:0]    frac_q;
  logic signed [17:0]      decay_q;

  // Sequencer outputs
  logic                    evt_take;
  logic                    out_free;
  logic                    out_load;
  logic                    mem_we;
  logic                    mem_re;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign evt_i.ready = (state_q == ST_IDLE);
  assign evt_take    = evt_i.valid && evt_i.ready;
  assign out_free    = !out_vld_q || res_o.ready;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // Running clock: add the wrap-corrected tick delta on every event transfer
  // ---------------------------------------------------------------------------
  logic [STAMP_BITS+23:0]  st_wide;
  logic [STAMP_BITS-1:0]   st_s;
  logic [STAMP_BITS-1:0]   st_diff;
  logic [TIME_BITS-1:0]    delta;

  assign st_wide = {{STAMP_BITS{1'b0}}, evt_i.data.stamp};
  assign st_s    = st_wide[STAMP_BITS-1:0];
  // Wrap the tick difference at the stamp width before widening it
  assign st_diff = st_s - prev_q;
  assign delta   = TIME_BITS'(st_diff);

  // Pixel inside the image and its linear address
  logic          inr_d;
  logic [AW-1:0] idx_d;

  assign inr_d = (12'(evt_q.pixel_x) < 12'(IMAGE_WIDTH)) &&
                 (12'(evt_q.pixel_y) < 12'(IMAGE_HEIGHT));
  assign idx_d = AW'(evt_q.pixel_y) * AW'(IMAGE_WIDTH) + AW'(evt_q.pixel_x);

  // ---------------------------------------------------------------------------
  // Pixel store: level and last update time per pixel
  // ---------------------------------------------------------------------------
  pixel_entry_t  rd_entry;
  pixel_entry_t  wr_entry;
  logic [EW-1:0] rd_raw;
  logic [AW-1:0] waddr;
  logic [15:0]   new_level;

  assign waddr    = (state_q == ST_CLEAR) ? clr_q : idx_q;
  assign wr_entry = (state_q == ST_CLEAR) ? pixel_entry_t'('0)
                                          : pixel_entry_t'({new_level, rt_q});
  assign rd_entry = pixel_entry_t'(rd_raw);

  edsu_pixel_mem #(
    .DEPTH (PIX),
    .WIDTH (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (EW'(wr_entry)),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier: rate x age low half, rate x age high half, magnitude x factor
  // ---------------------------------------------------------------------------
  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [MUL_BITS-1:0]   mul_d;

  always_comb begin
    case (state_q)
      ST_MLO: begin
        mul_a = rate_q;
        mul_b = age_q[19:0];
      end
      ST_MHI: begin
        mul_a = rate_q;
        mul_b = age_q[39:20];
      end
      default: begin
        mul_a = MUL_A_BITS'(mag_q);
        mul_b = MUL_B_BITS'(frac_q);
      end
    endcase
  end

  assign mul_d = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);

  // Exponent assembly: E = (p_hi << 20) + p_lo; it is exact when p_hi < 256
  logic [52:0] e_sum;
  logic        zero_d;

  assign e_sum  = {25'b0, mul_q[7:0], 20'b0} + {1'b0, plo_q};
  assign zero_d = (mul_q[MUL_BITS-1:8] != '0) || (e_sum[52:28] != '0);

  // Rounded shift by 16+n, halves away from zero on the magnitude
  logic [33:0] rnd_sum;
  logic [16:0] r_mag;
  logic signed [17:0] decay_d;

  assign rnd_sum = {1'b0, mul_q[32:0]} + (34'd1 << (6'd15 + 6'(n_q)));
  assign r_mag   = 17'(rnd_sum >> (6'd16 + 6'(n_q)));
  assign decay_d = zero_q ? 18'sd0
                 : (neg_q ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag}));

  // Add or subtract one in Q8.8 and saturate
  logic signed [17:0] sum;
  logic               sat;

  assign sum = decay_q + (evt_q.polarity ? ONE_Q88 : -ONE_Q88);

  always_comb begin
    if (sum > 18'sd32767) begin
      new_level = 16'h7FFF;
      sat       = 1'b1;
    end else if (sum < -18'sd32768) begin
      new_level = 16'h8000;
      sat       = 1'b1;
    end else begin
      new_level = sum[15:0];
      sat       = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(PIX - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (evt_take) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        state_d = inr_d ? ST_READ : ST_FIN;
      end
      ST_READ: state_d = ST_AGE;
      ST_AGE:  state_d = ST_MLO;
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = ST_EXP;
      ST_EXP:  state_d = ST_TAB;
      ST_TAB:  state_d = ST_MAG;
      ST_MAG:  state_d = ST_RND;
      ST_RND:  state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_READ:  mem_re = 1'b1;
      ST_FIN: begin
        out_load = out_free;
        mem_we   = out_free && inr_q;
      end
      default: begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rate_q    <= RATE_RESET;
      rt_q      <= '0;
      prev_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_i.valid) begin
        rate_q <= cfg_i.data;
      end
      if (evt_take) begin
        rt_q   <= rt_q + delta;
        prev_q <= st_s;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (evt_take) begin
      evt_q <= evt_i.data;
    end
    if (state_q == ST_ADDR) begin
      inr_q <= inr_d;
      idx_q <= idx_d;
    end
    if (state_q == ST_AGE) begin
      age_q <= rt_q - rd_entry.stamp_time;
      neg_q <= rd_entry.level[15];
      mag_q <= rd_entry.level[15] ? LEVEL_BITS'(-rd_entry.level) : rd_entry.level;
    end
    if (state_q == ST_MLO || state_q == ST_MHI || state_q == ST_MAG) begin
      mul_q <= mul_d;
    end
    if (state_q == ST_MHI) begin
      plo_q <= mul_q;
    end
    if (state_q == ST_EXP) begin
      zero_q <= zero_d;
      n_q    <= e_sum[27:24];
      f_q    <= e_sum[23:16];
    end
    if (state_q == ST_TAB) begin
      frac_q <= FRAC_TABLE[f_q];
    end
    if (state_q == ST_RND) begin
      decay_q <= decay_d;
    end
    if (out_load) begin
      out_q.out_x     <= evt_q.pixel_x;
      out_q.out_y     <= evt_q.pixel_y;
      out_q.new_value <= inr_q ? $signed(new_level) : 16'sd0;
      out_q.saturated <= inr_q && sat;
    end
  end

endmodule
